// ===== design/range_kth_smallest_macros.svh =====
// Assertion macros shared by the range k-th smallest checker.
// No dependencies; included by files that carry concurrent assertions.
`ifndef RANGE_KTH_SMALLEST_MACROS_SVH
`define RANGE_KTH_SMALLEST_MACROS_SVH

// Implication checked in the same cycle.
`define RKS_ASSERT_NOW(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |-> (cons)) \
        else $error("range_kth_smallest: assertion failed");

// Implication checked in the next cycle.
`define RKS_ASSERT_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge aclk) disable iff (!aresetn) (ante) |=> (cons)) \
        else $error("range_kth_smallest: assertion failed");

`endif

// ===== design/rks_pkg.sv =====
// Shared constants for the range k-th smallest block: field widths, codes, defaults.
// No dependencies.
package rks_pkg;

    localparam int MAX_ITEMS_DEF  = 1024;
    localparam int VALUE_BITS_DEF = 16;

    localparam int KIND_W   = 2;
    localparam int VALUE_W  = 16;
    localparam int POS_W    = 11;
    localparam int STATUS_W = 2;
    localparam int ANSWER_W = 16;

    localparam logic [KIND_W-1:0] KIND_APPEND = 2'd0;
    localparam logic [KIND_W-1:0] KIND_QUERY  = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK   = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_BAD  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_FULL = 2'd2;
    localparam logic [STATUS_W-1:0] STATUS_NONE = 2'd3;

endpackage

// ===== design/range_kth_smallest.sv =====
// Range k-th smallest over an append-only sequence, built on a persistent counting tree
// kept in two RAMs (tree nodes, version roots). Uses rks_pkg, rks_ram, rks_step.
//
// Each append writes VALUE_BITS+1 new nodes, one per tree level, with a read and a
// write of the node RAM per level. A query walks VALUE_BITS levels, three steps each
// (fetch node pair, fetch left children, compare counts). Clear, a rejected item or
// an unused kind goes straight from decode to the output state. One item is worked at
// a time; the next is taken once the result sits in the output register. Node and
// root RAMs need no clearing pass: entry zero reads as the empty node and every other
// entry is written before it is read.
module range_kth_smallest #(
    parameter int MAX_ITEMS  = rks_pkg::MAX_ITEMS_DEF,
    parameter int VALUE_BITS = rks_pkg::VALUE_BITS_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          s_valid,
    output logic                          s_ready,
    input  logic [rks_pkg::KIND_W-1:0]    s_kind,
    input  logic [rks_pkg::VALUE_W-1:0]   s_value,
    input  logic [rks_pkg::POS_W-1:0]     s_first_pos,
    input  logic [rks_pkg::POS_W-1:0]     s_last_pos,
    input  logic [rks_pkg::POS_W-1:0]     s_rank,
    output logic                          m_valid,
    input  logic                          m_ready,
    output logic [rks_pkg::STATUS_W-1:0]  m_status,
    output logic [rks_pkg::ANSWER_W-1:0]  m_answer
);
    import rks_pkg::*;

    localparam int NODE_DEPTH = 1 + MAX_ITEMS * (VALUE_BITS + 1);
    localparam int NODE_W     = $clog2(NODE_DEPTH);
    localparam int NCNT_W     = $clog2(NODE_DEPTH + 1);
    localparam int VER_W      = $clog2(MAX_ITEMS + 1);
    localparam int CNT_W      = $clog2(MAX_ITEMS + 1);
    localparam int WORD_W     = CNT_W + 2 * NODE_W;
    localparam int LVL_W      = $clog2(VALUE_BITS + 1);

    localparam logic [3:0] ST_IDLE   = 4'd0;
    localparam logic [3:0] ST_DECODE = 4'd1;
    localparam logic [3:0] ST_A_ROOT = 4'd2;
    localparam logic [3:0] ST_A_RD   = 4'd3;
    localparam logic [3:0] ST_A_WR   = 4'd4;
    localparam logic [3:0] ST_Q_ROOT = 4'd5;
    localparam logic [3:0] ST_Q_CH   = 4'd6;
    localparam logic [3:0] ST_Q_KID  = 4'd7;
    localparam logic [3:0] ST_Q_CMP  = 4'd8;
    localparam logic [3:0] ST_OUT    = 4'd9;

    // control state
    logic [3:0]            state_reg, state_next;
    logic                  m_valid_reg, m_valid_next;
    logic [VER_W-1:0]      item_count_reg, item_count_next;
    logic [NCNT_W-1:0]     node_count_reg, node_count_next;

    // work registers
    logic [KIND_W-1:0]     kind_reg, kind_next;
    logic [VALUE_BITS-1:0] val_reg, val_next;
    logic [POS_W-1:0]      first_reg, first_next;
    logic [POS_W-1:0]      last_reg, last_next;
    logic [POS_W-1:0]      rank_reg, rank_next;
    logic [CNT_W-1:0]      k_reg, k_next;
    logic [VALUE_BITS-1:0] result_reg, result_next;
    logic [LVL_W-1:0]      lvl_reg, lvl_next;
    logic [NODE_W-1:0]     prev_reg, prev_next;
    logic [NODE_W-1:0]     fresh_reg, fresh_next;
    logic [NODE_W-1:0]     hi_reg, hi_next;
    logic [NODE_W-1:0]     lo_reg, lo_next;
    logic [NODE_W-1:0]     hl_reg, hl_next;
    logic [NODE_W-1:0]     ll_reg, ll_next;
    logic [NODE_W-1:0]     hr_reg, hr_next;
    logic [NODE_W-1:0]     lr_reg, lr_next;
    logic [STATUS_W-1:0]   status_reg, status_next;
    logic [STATUS_W-1:0]   m_status_reg, m_status_next;
    logic [ANSWER_W-1:0]   m_answer_reg, m_answer_next;

    // RAM ports
    logic                  node_we;
    logic [NODE_W-1:0]     node_waddr, node_raddr0, node_raddr1;
    logic [WORD_W-1:0]     node_wdata, node_q0, node_q1, node_d0, node_d1;
    logic                  root_we;
    logic [VER_W-1:0]      root_waddr, root_raddr0, root_raddr1;
    logic [NODE_W-1:0]     root_wdata, root_q0, root_q1, root_d0, root_d1;
    logic                  nz0_reg, nz1_reg, rz0_reg, rz1_reg;

    // count unit
    logic [CNT_W-1:0]      step_a, step_b;
    logic                  take_left;
    logic [CNT_W-1:0]      k_rem, cnt_inc;

    logic                  query_ok;
    logic                  side;
    logic [NODE_W-1:0]     d0_left, d0_right, d1_left, d1_right;
    logic [CNT_W-1:0]      d0_cnt, d1_cnt;

    rks_ram #(.WIDTH(WORD_W), .DEPTH(NODE_DEPTH)) u_node_ram (
        .aclk   (aclk),
        .we     (node_we),
        .waddr  (node_waddr),
        .wdata  (node_wdata),
        .raddr0 (node_raddr0),
        .raddr1 (node_raddr1),
        .rdata0 (node_q0),
        .rdata1 (node_q1)
    );

    rks_ram #(.WIDTH(NODE_W), .DEPTH(MAX_ITEMS + 1)) u_root_ram (
        .aclk   (aclk),
        .we     (root_we),
        .waddr  (root_waddr),
        .wdata  (root_wdata),
        .raddr0 (root_raddr0),
        .raddr1 (root_raddr1),
        .rdata0 (root_q0),
        .rdata1 (root_q1)
    );

    rks_step #(.CNT_W(CNT_W)) u_step (
        .cnt_a     (step_a),
        .cnt_b     (step_b),
        .k         (k_reg),
        .take_left (take_left),
        .k_rem     (k_rem),
        .cnt_inc   (cnt_inc)
    );

    // entry zero of either RAM is never written and reads as the empty node
    assign node_d0 = nz0_reg ? '0 : node_q0;
    assign node_d1 = nz1_reg ? '0 : node_q1;
    assign root_d0 = rz0_reg ? '0 : root_q0;
    assign root_d1 = rz1_reg ? '0 : root_q1;

    assign d0_cnt   = node_d0[WORD_W-1 -: CNT_W];
    assign d0_left  = node_d0[2*NODE_W-1 -: NODE_W];
    assign d0_right = node_d0[NODE_W-1:0];
    assign d1_cnt   = node_d1[WORD_W-1 -: CNT_W];
    assign d1_left  = node_d1[2*NODE_W-1 -: NODE_W];
    assign d1_right = node_d1[NODE_W-1:0];

    assign step_a = d0_cnt;
    assign step_b = d1_cnt;
    assign side   = val_reg[VALUE_BITS-1];

    assign query_ok = (first_reg != '0) && (first_reg <= last_reg)
                   && (32'(last_reg) <= 32'(item_count_reg)) && (rank_reg != '0)
                   && (32'(rank_reg) <= 32'(last_reg) - 32'(first_reg) + 32'd1);

    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_status = m_status_reg;
    assign m_answer = m_answer_reg;

    always_comb begin
        state_next      = state_reg;
        m_valid_next    = m_valid_reg;
        item_count_next = item_count_reg;
        node_count_next = node_count_reg;
        kind_next       = kind_reg;
        val_next        = val_reg;
        first_next      = first_reg;
        last_next       = last_reg;
        rank_next       = rank_reg;
        k_next          = k_reg;
        result_next     = result_reg;
        lvl_next        = lvl_reg;
        prev_next       = prev_reg;
        fresh_next      = fresh_reg;
        hi_next         = hi_reg;
        lo_next         = lo_reg;
        hl_next         = hl_reg;
        ll_next         = ll_reg;
        hr_next         = hr_reg;
        lr_next         = lr_reg;
        status_next     = status_reg;
        m_status_next   = m_status_reg;
        m_answer_next   = m_answer_reg;

        node_we     = 1'b0;
        node_waddr  = fresh_reg;
        node_wdata  = '0;
        node_raddr0 = prev_reg;
        node_raddr1 = lo_reg;
        root_we     = 1'b0;
        root_waddr  = VER_W'(32'(item_count_reg) + 32'd1);
        root_wdata  = NODE_W'(node_count_reg);
        root_raddr0 = item_count_reg;
        root_raddr1 = VER_W'(last_reg);

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    kind_next   = s_kind;
                    val_next    = VALUE_BITS'(s_value);
                    first_next  = s_first_pos;
                    last_next   = s_last_pos;
                    rank_next   = s_rank;
                    lvl_next    = LVL_W'(VALUE_BITS);
                    result_next = '0;
                    status_next = STATUS_OK;
                    state_next  = ST_DECODE;
                end
            end
            ST_DECODE: begin
                unique case (kind_reg)
                    KIND_APPEND: begin
                        if (32'(item_count_reg) >= 32'(MAX_ITEMS)) begin
                            status_next = STATUS_FULL;
                            state_next  = ST_OUT;
                        end else begin
                            root_we    = 1'b1;
                            fresh_next = NODE_W'(node_count_reg);
                            state_next = ST_A_ROOT;
                        end
                    end
                    KIND_QUERY: begin
                        root_raddr0 = VER_W'(32'(first_reg) - 32'd1);
                        if (query_ok) begin
                            k_next     = CNT_W'(rank_reg);
                            state_next = ST_Q_ROOT;
                        end else begin
                            status_next = STATUS_BAD;
                            state_next  = ST_OUT;
                        end
                    end
                    KIND_CLEAR: begin
                        item_count_next = '0;
                        node_count_next = NCNT_W'(1);
                        state_next      = ST_OUT;
                    end
                    default: begin
                        state_next = ST_OUT;
                    end
                endcase
            end
            ST_A_ROOT: begin
                prev_next  = root_d0;
                state_next = ST_A_RD;
            end
            ST_A_RD: begin
                node_raddr0 = prev_reg;
                state_next  = ST_A_WR;
            end
            ST_A_WR: begin
                node_we = 1'b1;
                if (lvl_reg != '0) begin
                    // copy the old node, bump its count, point the taken side at the next fresh node
                    if (side) begin
                        node_wdata = {cnt_inc, d0_left, fresh_reg + NODE_W'(1)};
                        prev_next  = d0_right;
                    end else begin
                        node_wdata = {cnt_inc, fresh_reg + NODE_W'(1), d0_right};
                        prev_next  = d0_left;
                    end
                    val_next   = val_reg << 1;
                    fresh_next = fresh_reg + NODE_W'(1);
                    lvl_next   = lvl_reg - LVL_W'(1);
                    state_next = ST_A_RD;
                end else begin
                    node_wdata      = {cnt_inc, {(2*NODE_W){1'b0}}};
                    node_count_next = node_count_reg + NCNT_W'(VALUE_BITS + 1);
                    item_count_next = item_count_reg + VER_W'(1);
                    state_next      = ST_OUT;
                end
            end
            ST_Q_ROOT: begin
                lo_next    = root_d0;
                hi_next    = root_d1;
                state_next = ST_Q_CH;
            end
            ST_Q_CH: begin
                node_raddr0 = hi_reg;
                node_raddr1 = lo_reg;
                state_next  = ST_Q_KID;
            end
            ST_Q_KID: begin
                hl_next     = d0_left;
                hr_next     = d0_right;
                ll_next     = d1_left;
                lr_next     = d1_right;
                node_raddr0 = d0_left;
                node_raddr1 = d1_left;
                state_next  = ST_Q_CMP;
            end
            ST_Q_CMP: begin
                // node_d0/d1 hold the left children of hi and lo
                if (take_left) begin
                    hi_next     = hl_reg;
                    lo_next     = ll_reg;
                    result_next = result_reg << 1;
                end else begin
                    hi_next     = hr_reg;
                    lo_next     = lr_reg;
                    k_next      = k_rem;
                    result_next = (result_reg << 1) | VALUE_BITS'(1);
                end
                lvl_next = lvl_reg - LVL_W'(1);
                if (lvl_reg == LVL_W'(1)) begin
                    state_next = ST_OUT;
                end else begin
                    state_next = ST_Q_CH;
                end
            end
            ST_OUT: begin
                if (!m_valid_reg || m_ready) begin
                    m_valid_next  = 1'b1;
                    m_status_next = status_reg;
                    if (kind_reg == KIND_QUERY && status_reg == STATUS_OK) begin
                        m_answer_next = ANSWER_W'(result_reg);
                    end else begin
                        m_answer_next = '0;
                    end
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg      <= ST_IDLE;
            m_valid_reg    <= 1'b0;
            item_count_reg <= '0;
            node_count_reg <= NCNT_W'(1);
        end else begin
            state_reg      <= state_next;
            m_valid_reg    <= m_valid_next;
            item_count_reg <= item_count_next;
            node_count_reg <= node_count_next;
        end
    end

    always_ff @(posedge aclk) begin
        kind_reg     <= kind_next;
        val_reg      <= val_next;
        first_reg    <= first_next;
        last_reg     <= last_next;
        rank_reg     <= rank_next;
        k_reg        <= k_next;
        result_reg   <= result_next;
        lvl_reg      <= lvl_next;
        prev_reg     <= prev_next;
        fresh_reg    <= fresh_next;
        hi_reg       <= hi_next;
        lo_reg       <= lo_next;
        hl_reg       <= hl_next;
        ll_reg       <= ll_next;
        hr_reg       <= hr_next;
        lr_reg       <= lr_next;
        status_reg   <= status_next;
        m_status_reg <= m_status_next;
        m_answer_reg <= m_answer_next;
        nz0_reg      <= (node_raddr0 == '0);
        nz1_reg      <= (node_raddr1 == '0);
        rz0_reg      <= (root_raddr0 == '0);
        rz1_reg      <= (root_raddr1 == '0);
    end
endmodule

// ===== design/rks_ram.sv =====
// Generic RAM: one write port, two read ports, registered read data.
// No dependencies.
module rks_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr0,
    input  logic [$clog2(DEPTH)-1:0] raddr1,
    output logic [WIDTH-1:0]         rdata0,
    output logic [WIDTH-1:0]         rdata1
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata0 <= mem[raddr0];
        rdata1 <= mem[raddr1];
    end
endmodule

// ===== design/rks_step.sv =====
// Shared count unit: left-subtree difference, rank compare and remainder, increment.
// No dependencies.
module rks_step #(
    parameter int CNT_W = 11
) (
    input  logic [CNT_W-1:0] cnt_a,
    input  logic [CNT_W-1:0] cnt_b,
    input  logic [CNT_W-1:0] k,
    output logic             take_left,
    output logic [CNT_W-1:0] k_rem,
    output logic [CNT_W-1:0] cnt_inc
);
    logic [CNT_W-1:0] diff;

    assign diff      = cnt_a - cnt_b;
    assign take_left = (diff >= k);
    assign k_rem     = k - diff;
    assign cnt_inc   = cnt_a + CNT_W'(1);
endmodule

// ===== design/rks_checker.sv =====
// Port-level checker for range_kth_smallest, attached by bind.
// Uses rks_pkg and range_kth_smallest_macros.svh.
`include "range_kth_smallest_macros.svh"

module rks_checker (
    input logic                          aclk,
    input logic                          aresetn,
    input logic                          s_valid,
    input logic                          s_ready,
    input logic                          m_valid,
    input logic                          m_ready,
    input logic [rks_pkg::STATUS_W-1:0]  m_status,
    input logic [rks_pkg::ANSWER_W-1:0]  m_answer
);
    import rks_pkg::*;

    // hold a stalled result
    `RKS_ASSERT_NEXT(a_out_hold, m_valid && !m_ready, m_valid && $stable(m_status) && $stable(m_answer))
    // never a reserved status code
    `RKS_ASSERT_NOW(a_status_code, m_valid, m_status != STATUS_NONE)
    // a rejected item carries no answer
    `RKS_ASSERT_NOW(a_reject_zero, m_valid && m_status != STATUS_OK, m_answer == '0)
    // busy in the cycle after each input transfer
    `RKS_ASSERT_NEXT(a_busy_after_in, s_valid && s_ready, !s_ready)
endmodule

bind range_kth_smallest rks_checker u_rks_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_valid  (s_valid),
    .s_ready  (s_ready),
    .m_valid  (m_valid),
    .m_ready  (m_ready),
    .m_status (m_status),
    .m_answer (m_answer)
);
